// ----- rtl/core/olst_pkg.sv -----
// Shared definitions for the ordered list engine: action codes, cell
// operations, sequencer states and scan result type. No dependencies.
`timescale 1ns / 1ps

package olst_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 32;

	// Number of cell match flags the search scanner examines per cycle.
	localparam int SCAN_GROUP = 8;

	typedef enum logic [2:0] {
		ACT_SEARCH = 3'd0,
		ACT_READ   = 3'd1,
		ACT_WRITE  = 3'd2,
		ACT_INSERT = 3'd3,
		ACT_REMOVE = 3'd4,
		ACT_CLEAR  = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		CELL_HOLD       = 2'd0,
		CELL_LOAD       = 2'd1,
		CELL_SHIFT_UP   = 2'd2,
		CELL_SHIFT_DOWN = 2'd3
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_SCAN = 2'd2,
		ST_RESP = 2'd3
	} state_t;

	typedef struct packed {
		logic done;
		logic hit;
	} scan_res_t;

endpackage

// ----- rtl/core/olst_cell.sv -----
// One storage cell of the list chain: holds a word, loads, takes a word from
// either neighbour and compares against the search key. Depends on olst_pkg.
`timescale 1ns / 1ps

module olst_cell #(
	parameter int DATA_WIDTH = olst_pkg::DEF_DATA_WIDTH
) (
	input  logic                  clk,
	input  olst_pkg::cell_op_t    op,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  match
);
	import olst_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD:       data_q <= value;
			CELL_SHIFT_UP:   data_q <= left;
			CELL_SHIFT_DOWN: data_q <= right;
			default:         data_q <= data_q;
		endcase
	end

	assign data  = data_q;
	assign match = (data_q == value);

endmodule

// ----- rtl/core/olst_scan.sv -----
// Search scanner: walks the registered match flags a group at a time and
// reports the first set flag. Depends on olst_pkg.
`timescale 1ns / 1ps

module olst_scan #(
	parameter int CAPACITY = olst_pkg::DEF_CAPACITY,
	localparam int IDX_W   = $clog2(CAPACITY)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [CAPACITY-1:0]     hits,
	output olst_pkg::scan_res_t     res,
	output logic [IDX_W-1:0]        index
);
	import olst_pkg::*;

	localparam int NGRP  = (CAPACITY + SCAN_GROUP - 1) / SCAN_GROUP;
	localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int SUB_W = $clog2(SCAN_GROUP);
	localparam int PAD_W = NGRP * SCAN_GROUP;

	logic             busy_q;
	logic [GRP_W-1:0] grp_q;
	logic [PAD_W-1:0] hits_pad;
	logic [SCAN_GROUP-1:0] slice;
	logic [SUB_W-1:0] sub;
	logic             any;
	logic             last;

	assign hits_pad = PAD_W'(hits);
	assign slice    = hits_pad[grp_q * SCAN_GROUP +: SCAN_GROUP];
	assign any      = |slice;
	assign last     = (grp_q == GRP_W'(NGRP - 1));

	// Lowest set flag in the current group wins.
	always_comb begin
		sub = '0;
		for (int i = SCAN_GROUP - 1; i >= 0; i--) begin
			if (slice[i]) begin
				sub = SUB_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			grp_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			grp_q  <= '0;
		end else if (busy_q) begin
			if (any || last) begin
				busy_q <= 1'b0;
			end else begin
				grp_q <= grp_q + 1'b1;
			end
		end
	end

	assign res.done = busy_q && (any || last);
	assign res.hit  = busy_q && any;
	assign index    = IDX_W'({grp_q, sub});

endmodule

// ----- rtl/core/ordered_list_engine_core.sv -----
// Top level of the ordered list engine: sequencer, chain of list cells,
// search scanner and output register. Depends on olst_pkg, olst_cell, olst_scan.
`timescale 1ns / 1ps

// The engine keeps an ordered list of up to CAPACITY words in a row of cells,
// one word per cell, with the front of the list in cell 0. Each input
// transaction carries an action (search, read, write, insert after, remove or
// clear), a 1-based position and a word, and produces exactly one output
// transaction giving ok, the word read or removed, the position found by a
// search and the list length after the action. Insert and remove move every
// cell above the position by one place at once, since each cell takes its
// neighbour's word. A non-search transaction passes through accept, execute
// and hand to the output register, and the engine accepts no new one until
// it is back at idle. A search adds a scan, in which the scanner examines
// the cell match flags eight at a time from the front. The output register
// lets the next transaction be accepted while a result is still waiting to
// be taken. There is no clearing pass: after reset the list is simply
// empty.

module ordered_list_engine_core #(
	parameter int CAPACITY   = olst_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = olst_pkg::DEF_DATA_WIDTH,
	localparam int POS_W     = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [2:0]            action,
	input  logic [POS_W-1:0]      position,
	input  logic [DATA_WIDTH-1:0] value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  ok,
	output logic [DATA_WIDTH-1:0] data_out,
	output logic [POS_W-1:0]      found_position,
	output logic [POS_W-1:0]      length
);
	import olst_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);

	state_t state_q, state_d;

	// Captured transaction.
	action_t               action_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] val_q;

	logic [POS_W-1:0] count_q, count_d;

	// Result awaiting the output register.
	logic                  res_ok_q;
	logic [DATA_WIDTH-1:0] res_data_q;
	logic [POS_W-1:0]      res_found_q;
	logic [POS_W-1:0]      res_len_q;

	// Output register.
	logic                  out_valid_q;
	logic                  out_ok_q;
	logic [DATA_WIDTH-1:0] out_data_q;
	logic [POS_W-1:0]      out_found_q;
	logic [POS_W-1:0]      out_len_q;

	logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
	logic [CAPACITY-1:0]   cell_match;
	cell_op_t              cell_op    [CAPACITY];
	logic [CAPACITY-1:0]   match_s1;

	logic             accept_in;
	logic             exec_en;
	logic             scan_start;
	logic             load_out;
	logic             out_free;
	logic             pos_ok;
	logic             ins_ok;
	logic             act_ok;
	logic [POS_W-1:0] pos_m1;
	logic [DATA_WIDTH-1:0] rd_data;

	scan_res_t        scan_res;
	logic [IDX_W-1:0] scan_idx;

	assign accept_in = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign pos_m1    = pos_q - 1'b1;

	// A position addresses an element when it lies between 1 and the length;
	// insert also accepts position 0 (the front) but needs a free cell.
	assign pos_ok = (pos_q != '0) && (pos_q <= count_q);
	assign ins_ok = (pos_q <= count_q) && (count_q < POS_W'(CAPACITY));

	// The read mux only matters when pos_ok holds, so pos_m1 is then in range.
	assign rd_data = cell_data[pos_m1[IDX_W-1:0]];

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (action_q == ACT_SEARCH) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_SCAN: begin
				if (scan_res.done) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		exec_en    = 1'b0;
		scan_start = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_EXEC: begin
				exec_en    = 1'b1;
				scan_start = (action_q == ACT_SEARCH);
			end
			ST_RESP: load_out = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (exec_en) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			action_q <= action_t'(action);
			pos_q    <= position;
			val_q    <= value;
		end
	end

	// ------------------------------------------------------------------
	// Action decode: success flag and the new length.
	// ------------------------------------------------------------------
	always_comb begin
		act_ok  = 1'b0;
		count_d = count_q;
		case (action_q)
			ACT_READ:   act_ok = pos_ok;
			ACT_WRITE:  act_ok = pos_ok;
			ACT_INSERT: begin
				act_ok = ins_ok;
				if (ins_ok) begin
					count_d = count_q + 1'b1;
				end
			end
			ACT_REMOVE: begin
				act_ok = pos_ok;
				if (pos_ok) begin
					count_d = count_q - 1'b1;
				end
			end
			ACT_CLEAR: begin
				act_ok  = 1'b1;
				count_d = '0;
			end
			default: act_ok = 1'b0;
		endcase
	end

	// ------------------------------------------------------------------
	// Cell chain. Each cell works out its own operation from its place in
	// the row relative to the target position.
	// ------------------------------------------------------------------
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		localparam logic [POS_W-1:0] K = POS_W'(k);
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (k == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[k-1];
		end

		if (k == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[k+1];
		end

		always_comb begin
			cell_op[k] = CELL_HOLD;
			if (exec_en) begin
				case (action_q)
					ACT_WRITE: begin
						if (pos_ok && (K == pos_m1)) begin
							cell_op[k] = CELL_LOAD;
						end
					end
					ACT_INSERT: begin
						if (ins_ok && (K == pos_q)) begin
							cell_op[k] = CELL_LOAD;
						end else if (ins_ok && (K > pos_q)) begin
							cell_op[k] = CELL_SHIFT_UP;
						end
					end
					ACT_REMOVE: begin
						if (pos_ok && (K >= pos_m1)) begin
							cell_op[k] = CELL_SHIFT_DOWN;
						end
					end
					default: cell_op[k] = CELL_HOLD;
				endcase
			end
		end

		olst_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk   (clk),
			.op    (cell_op[k]),
			.value (val_q),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[k]),
			.match (cell_match[k])
		);

		// Only cells holding list words may report a match.
		always_ff @(posedge clk) begin
			if (scan_start) begin
				match_s1[k] <= cell_match[k] && (K < count_q);
			end
		end
	end

	olst_scan #(
		.CAPACITY(CAPACITY)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.hits   (match_s1),
		.res    (scan_res),
		.index  (scan_idx)
	);

	// ------------------------------------------------------------------
	// Result capture and output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (exec_en && (action_q != ACT_SEARCH)) begin
			res_ok_q    <= act_ok;
			res_found_q <= '0;
			res_len_q   <= count_d;
			if (pos_ok && ((action_q == ACT_READ) || (action_q == ACT_REMOVE))) begin
				res_data_q <= rd_data;
			end else begin
				res_data_q <= '0;
			end
		end else if ((state_q == ST_SCAN) && scan_res.done) begin
			res_ok_q    <= scan_res.hit;
			res_data_q  <= '0;
			res_found_q <= scan_res.hit ? (POS_W'(scan_idx) + 1'b1) : '0;
			res_len_q   <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ok_q    <= res_ok_q;
			out_data_q  <= res_data_q;
			out_found_q <= res_found_q;
			out_len_q   <= res_len_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = out_ok_q;
	assign data_out       = out_data_q;
	assign found_position = out_found_q;
	assign length         = out_len_q;

endmodule
